// ===== rtl/qfas_pkg.sv =====
// Shared types and constants for the binary128 adder/subtractor.
// No dependencies.
`default_nettype none
package qfas_pkg;

  localparam int unsigned ExpW   = 15;
  localparam int unsigned FracW  = 112;
  localparam int unsigned SigW   = 116;   // hidden + fraction + guard/round/sticky
  localparam int unsigned LzcW   = 7;
  localparam logic [ExpW-1:0] ExpMax = 15'h7fff;
  localparam logic [63:0] QnanHi = 64'h7fff800000000000;
  localparam logic [63:0] InfHi  = 64'h7fff000000000000;

  typedef struct packed {
    logic        action;
    logic [63:0] a_high;
    logic [63:0] a_low;
    logic [63:0] b_high;
    logic [63:0] b_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] sum_high;
    logic [63:0] sum_low;
    logic        flag_invalid;
    logic        flag_overflow;
    logic        flag_underflow;
    logic        flag_inexact;
  } out_word_t;

  // Stage 1 -> 2: operands ordered by magnitude, special cases resolved.
  typedef struct packed {
    logic              special;
    out_word_t         spec_res;
    logic              sign;
    logic              sub;
    logic [ExpW-1:0]   ea;
    logic [ExpW-1:0]   eb;
    logic [FracW:0]    ma;
    logic [FracW:0]    mb;
  } align_t;

  // Stage 2 -> 3: raw sum.
  typedef struct packed {
    logic              special;
    out_word_t         spec_res;
    logic              sign;
    logic [ExpW-1:0]   ea;
    logic [SigW:0]     sum;
  } sum_t;

  // Stage 3 -> 4: normalized significand.
  typedef struct packed {
    logic              special;
    out_word_t         spec_res;
    logic              sign;
    logic              zero;
    logic [ExpW+1:0]   e;
    logic [SigW-1:0]   sig;
  } norm_t;

  // Leading one position of a 117-bit word, -1 encoded as all ones on zero.
  function automatic logic [LzcW:0] msb_pos(input logic [SigW:0] v);
    logic [LzcW:0] p;
    p = '1;
    for (int i = 0; i <= SigW; i++) begin
      if (v[i]) p = (LzcW+1)'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/quad_float_add_sub.sv =====
// Top level: four-stage binary128 add/sub pipeline with valid/ready handshake.
// Depends on qfas_pkg, qfas_unpack, qfas_align, qfas_norm, qfas_round.
//
//   channel | valid     | ready     | word
//   in      | in_valid_i| in_ready_o| in_word_i  (qfas_pkg::in_word_t)
//   out     | out_valid_o| out_ready_i| out_word_o (qfas_pkg::out_word_t)
//
// One word per cycle unless out_ready_i stalls the pipe; the stages are unpack, align/add, normalize, round.
// Reset clears the stage valid bits only; data registers are not reset.
// A stall holds every stage whose successor is full; bubbles are squeezed out.
`default_nettype none
module quad_float_add_sub (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire qfas_pkg::in_word_t in_word_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output qfas_pkg::out_word_t   out_word_o
);
  import qfas_pkg::*;

  align_t    s1_d, s1_q;
  sum_t      s2_d, s2_q;
  norm_t     s3_d, s3_q;
  out_word_t s4_d, s4_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  qfas_unpack u_unpack (.in_i(in_word_i), .out_o(s1_d));
  qfas_align  u_align  (.in_i(s1_q), .out_o(s2_d));
  qfas_norm   u_norm   (.in_i(s2_q), .out_o(s3_d));
  qfas_round  u_round  (.in_i(s3_q), .out_o(s4_d));

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;
  assign out_word_o  = s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
    if (en3 && v2_q) s3_q <= s3_d;
    if (en4 && v3_q) s4_q <= s4_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !en4 |=> v3_q && v4_q)
    else $error("stage 3 word lost");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && v4_q && !out_ready_i)
    else $error("input stalled with room in pipeline");
endmodule
`default_nettype wire

// ===== rtl/qfas_unpack.sv =====
// Stage 1: operand decode, special cases, magnitude swap.
// Depends on qfas_pkg.
`default_nettype none
module qfas_unpack (
  input  wire qfas_pkg::in_word_t in_i,
  output qfas_pkg::align_t   out_o
);
  import qfas_pkg::*;

  logic [63:0] ah, bh, xh, xl, yh, yl;
  logic [ExpW-1:0] ea, eb, ex, ey;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;

  always_comb begin
    ah = in_i.a_high;
    bh = in_i.b_high ^ {in_i.action, 63'd0};
    ea = ah[62:48];
    eb = bh[62:48];
    a_nan  = (ea == ExpMax) && ({ah[47:0], in_i.a_low} != '0);
    b_nan  = (eb == ExpMax) && ({bh[47:0], in_i.b_low} != '0);
    a_inf  = (ea == ExpMax);
    b_inf  = (eb == ExpMax);
    a_zero = ({ah[62:0], in_i.a_low} == '0);
    b_zero = ({bh[62:0], in_i.b_low} == '0);

    out_o = '0;
    out_o.special = 1'b1;
    if (a_nan || b_nan) begin
      out_o.spec_res.sum_high = QnanHi;
    end else if (a_inf || b_inf) begin
      if (a_inf && b_inf && (ah[63] != bh[63])) begin
        out_o.spec_res.sum_high = QnanHi;
        out_o.spec_res.flag_invalid = 1'b1;
      end else if (a_inf) begin
        out_o.spec_res.sum_high = ah;
        out_o.spec_res.sum_low  = in_i.a_low;
      end else begin
        out_o.spec_res.sum_high = bh;
        out_o.spec_res.sum_low  = in_i.b_low;
      end
    end else if (a_zero) begin
      if (!(b_zero && (ah[63] != bh[63]))) begin
        out_o.spec_res.sum_high = bh;
        out_o.spec_res.sum_low  = in_i.b_low;
      end
    end else if (b_zero) begin
      out_o.spec_res.sum_high = ah;
      out_o.spec_res.sum_low  = in_i.a_low;
    end else begin
      out_o.special = 1'b0;
    end

    swap = {ah[62:0], in_i.a_low} < {bh[62:0], in_i.b_low};
    xh = swap ? bh : ah;
    xl = swap ? in_i.b_low : in_i.a_low;
    yh = swap ? ah : bh;
    yl = swap ? in_i.a_low : in_i.b_low;
    ex = xh[62:48];
    ey = yh[62:48];
    out_o.sign = xh[63];
    out_o.sub  = xh[63] ^ yh[63];
    out_o.ea   = (ex == '0) ? ExpW'(1) : ex;
    out_o.eb   = (ey == '0) ? ExpW'(1) : ey;
    out_o.ma   = {(ex != '0), xh[47:0], xl};
    out_o.mb   = {(ey != '0), yh[47:0], yl};
  end
endmodule
`default_nettype wire

// ===== rtl/qfas_align.sv =====
// Stage 2: align smaller operand with sticky, then add or subtract.
// Depends on qfas_pkg.
`default_nettype none
module qfas_align (
  input  wire qfas_pkg::align_t in_i,
  output qfas_pkg::sum_t   out_o
);
  import qfas_pkg::*;

  logic [ExpW-1:0] d;
  logic [SigW-1:0] sa, sb, sh;
  logic            sticky;

  always_comb begin
    d  = in_i.ea - in_i.eb;
    sa = {in_i.ma, 3'b000};
    sb = {in_i.mb, 3'b000};
    if (d >= ExpW'(SigW)) begin
      sh     = '0;
      sticky = (sb != '0);
    end else begin
      sh     = sb >> d;
      sticky = ((sh << d) != sb);
    end
    sh[0] = sh[0] | sticky;
    out_o.special  = in_i.special;
    out_o.spec_res = in_i.spec_res;
    out_o.sign     = in_i.sign;
    out_o.ea       = in_i.ea;
    out_o.sum      = in_i.sub ? ({1'b0, sa} - {1'b0, sh}) : ({1'b0, sa} + {1'b0, sh});
  end
endmodule
`default_nettype wire

// ===== rtl/qfas_norm.sv =====
// Stage 3: normalize sum to 116-bit significand with the leading one at bit 115 unless the exponent reaches 1.
// Depends on qfas_pkg.
`default_nettype none
module qfas_norm (
  input  wire qfas_pkg::sum_t  in_i,
  output qfas_pkg::norm_t out_o
);
  import qfas_pkg::*;

  logic [LzcW:0]   h;
  logic [ExpW+1:0] e, dl;
  logic [SigW:0]   r;

  always_comb begin
    h  = msb_pos(in_i.sum);
    e  = (ExpW+2)'(in_i.ea);
    r  = in_i.sum;
    dl = '0;
    if (h == (LzcW+1)'(SigW)) begin
      r = {1'b0, in_i.sum[SigW:2], in_i.sum[1] | in_i.sum[0]};
      e = e + 1'b1;
    end else if (h < (LzcW+1)'(SigW-1) && e > (ExpW+2)'(1)) begin
      dl = (ExpW+2)'((LzcW+1)'(SigW-1) - h);
      if (dl > e - 1'b1) dl = e - 1'b1;
      r = in_i.sum << dl;
      e = e - dl;
    end
    out_o.special  = in_i.special;
    out_o.spec_res = in_i.spec_res;
    out_o.sign     = in_i.sign;
    out_o.zero     = (in_i.sum == '0);
    out_o.e        = e;
    out_o.sig      = r[SigW-1:0];
  end
endmodule
`default_nettype wire

// ===== rtl/qfas_round.sv =====
// Stage 4: round to nearest even, overflow and subnormal packing.
// Depends on qfas_pkg.
`default_nettype none
module qfas_round (
  input  wire qfas_pkg::norm_t   in_i,
  output qfas_pkg::out_word_t out_o
);
  import qfas_pkg::*;

  logic [2:0]      rb;
  logic [FracW+1:0] m;
  logic [ExpW+1:0] e;
  logic            up;

  always_comb begin
    rb = in_i.sig[2:0];
    up = (rb > 3'd4) || (rb == 3'd4 && in_i.sig[3]);
    m  = {1'b0, in_i.sig[SigW-1:3]} + (FracW+2)'(up);
    e  = in_i.e;
    if (m[FracW+1]) begin
      m = m >> 1;
      e = e + 1'b1;
    end
    out_o = '0;
    if (in_i.special) begin
      out_o = in_i.spec_res;
    end else if (in_i.zero) begin
      out_o = '0;
    end else if (e >= (ExpW+2)'(ExpMax)) begin
      out_o.sum_high      = {in_i.sign, InfHi[62:0]};
      out_o.flag_overflow = 1'b1;
      out_o.flag_inexact  = 1'b1;
    end else begin
      out_o.sum_high = {in_i.sign, (m[FracW] ? e[ExpW-1:0] : ExpW'(0)), m[FracW-1:64]};
      out_o.sum_low  = m[63:0];
      out_o.flag_inexact   = (rb != '0);
      out_o.flag_underflow = !m[FracW] && (rb != '0);
    end
  end
endmodule
`default_nettype wire
